>>> rtl/core/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_PROP(lbl, clk, rst, !(cond), msg)

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

>>> rtl/core/sps_pkg.sv
// types and constants of the pan scan sequencer
`default_nettype none

package sps_pkg;

   localparam logic [11:0] ANGLE_FULL  = 12'd2880;
   localparam logic [11:0] CENTER_INIT = 12'd1440;
   localparam logic [31:0] IR_HOLD_MS  = 32'd1000;

   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PAN_CENTER       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_MIN          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_MAX          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_STEP       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_PERIOD_MS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GLANCE_STEP      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GLANCE_PERIOD_MS = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GLANCE_HOLD_MS   = 3'd7;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_OUT  = 2'd1,
      PH_HOLD = 2'd2,
      PH_BACK = 2'd3
   } phase_type;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic               ir_seen;
      logic               in_motion;
      logic [15:0]        glance_delay_ms;
      logic signed [11:0] glance_offset;
   } req_type;

   typedef struct packed {
      logic [11:0] pan_angle;
      logic        angle_written;
      logic [1:0]  glance_phase;
      logic        sweeping_down;
   } rsp_type;

   typedef struct packed {
      logic [11:0] pan_center;
      logic [11:0] pan_min;
      logic [11:0] pan_max;
      logic [9:0]  sweep_step;
      logic [15:0] sweep_period_ms;
      logic [9:0]  glance_step;
      logic [15:0] glance_period_ms;
      logic [15:0] glance_hold_ms;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/core/sps_csr.sv
// configuration register file
`default_nettype none

module sps_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [sps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                   csr_data,
   output sps_pkg::cfg_type                   cfg
);
   import sps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PAN_CENTER:       cfg_in.pan_center       = csr_data[11:0];
            CSR_PAN_MIN:          cfg_in.pan_min          = csr_data[11:0];
            CSR_PAN_MAX:          cfg_in.pan_max          = csr_data[11:0];
            CSR_SWEEP_STEP:       cfg_in.sweep_step       = csr_data[9:0];
            CSR_SWEEP_PERIOD_MS:  cfg_in.sweep_period_ms  = csr_data;
            CSR_GLANCE_STEP:      cfg_in.glance_step      = csr_data[9:0];
            CSR_GLANCE_PERIOD_MS: cfg_in.glance_period_ms = csr_data;
            CSR_GLANCE_HOLD_MS:   cfg_in.glance_hold_ms   = csr_data;
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pan_center       <= CENTER_INIT;
         cfg_ff.pan_min          <= 12'd480;
         cfg_ff.pan_max          <= 12'd2400;
         cfg_ff.sweep_step       <= 10'd48;
         cfg_ff.sweep_period_ms  <= 16'd60;
         cfg_ff.glance_step      <= 10'd64;
         cfg_ff.glance_period_ms <= 16'd20;
         cfg_ff.glance_hold_ms   <= 16'd400;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sps_engine.sv
// sequencer state and the single-pass tick logic
`default_nettype none

module sps_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire sps_pkg::req_type item,
   input  wire sps_pkg::cfg_type cfg,
   output sps_pkg::rsp_type      result
);
   import sps_pkg::*;

   logic [11:0] angle_ff, angle_in;
   logic        down_ff, down_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] beacon_ff, beacon_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] next_ff, next_in;
   logic [31:0] hold_ff, hold_in;
   logic [11:0] target_ff, target_in;
   logic        moved_ff, moved_in;

   logic        stop_edge;
   logic [11:0] angle_eff;
   logic [31:0] next_eff;
   logic [31:0] since_last;
   logic        glance_due;
   logic        sweep_due;

   // clamped glance target
   logic signed [13:0] tsum;
   logic [11:0]        tclamp;

   // shared approach toward target or centre
   logic [11:0]        goal;
   logic signed [12:0] delta;
   logic [12:0]        mag;
   logic               appr_done;
   logic [11:0]        appr_angle;

   // sweep step
   logic signed [13:0] sweep_sum;
   logic signed [13:0] sweep_inc;

   logic written;

   assign stop_edge  = !item.in_motion && moved_ff;
   assign angle_eff  = stop_edge ? cfg.pan_center : angle_ff;
   assign next_eff   = (next_ff == 32'd0) ? item.now_ms + {16'd0, item.glance_delay_ms}
                                          : next_ff;
   assign since_last = item.now_ms - last_ff;
   assign glance_due = !(since_last < {16'd0, cfg.glance_period_ms});
   assign sweep_due  = !(since_last < {16'd0, cfg.sweep_period_ms});

   assign tsum = $signed({2'b00, cfg.pan_center}) +
                 $signed({{2{item.glance_offset[11]}}, item.glance_offset});
   always_comb begin
      if (tsum[13]) begin
         tclamp = 12'd0;
      end else if (tsum > $signed({2'b00, ANGLE_FULL})) begin
         tclamp = ANGLE_FULL;
      end else begin
         tclamp = tsum[11:0];
      end
   end

   assign goal       = (phase_ff == PH_OUT) ? target_ff : cfg.pan_center;
   assign delta      = $signed({1'b0, goal}) - $signed({1'b0, angle_ff});
   assign mag        = delta[12] ? 13'(-delta) : 13'(delta);
   assign appr_done  = mag <= {3'b000, cfg.glance_step};
   always_comb begin
      if (appr_done) begin
         appr_angle = goal;
      end else if (delta[12]) begin
         appr_angle = angle_ff - {2'b00, cfg.glance_step};
      end else begin
         appr_angle = angle_ff + {2'b00, cfg.glance_step};
      end
   end

   assign sweep_inc = down_ff ? -$signed({4'b0000, cfg.sweep_step})
                              : $signed({4'b0000, cfg.sweep_step});
   assign sweep_sum = $signed({2'b00, angle_eff}) + sweep_inc;

   always_comb begin
      angle_in  = angle_ff;
      down_in   = down_ff;
      last_in   = last_ff;
      beacon_in = beacon_ff;
      phase_in  = phase_ff;
      next_in   = next_ff;
      hold_in   = hold_ff;
      target_in = target_ff;
      moved_in  = moved_ff;
      written   = 1'b0;
      if (item.ir_seen) begin
         beacon_in = item.now_ms + IR_HOLD_MS;
         written   = 1'b1;
      end else begin
         moved_in = item.in_motion;
         if (stop_edge) begin
            phase_in = PH_WAIT;
            next_in  = 32'd0;
            angle_in = cfg.pan_center;
            written  = 1'b1;
         end
         if (item.in_motion) begin
            next_in = next_eff;
            if (phase_ff == PH_WAIT) begin
               angle_in = cfg.pan_center;
               written  = 1'b1;
               if (item.now_ms >= next_eff) begin
                  target_in = tclamp;
                  phase_in  = PH_OUT;
                  last_in   = item.now_ms;
               end
            end else if (glance_due) begin
               last_in = item.now_ms;
               case (phase_ff)
                  PH_OUT: begin
                     angle_in = appr_angle;
                     written  = 1'b1;
                     if (appr_done) begin
                        phase_in = PH_HOLD;
                        hold_in  = item.now_ms + {16'd0, cfg.glance_hold_ms};
                     end
                  end
                  PH_HOLD: begin
                     if (item.now_ms >= hold_ff) begin
                        phase_in = PH_BACK;
                     end
                  end
                  PH_BACK: begin
                     angle_in = appr_angle;
                     written  = 1'b1;
                     if (appr_done) begin
                        phase_in = PH_WAIT;
                        next_in  = item.now_ms + {16'd0, item.glance_delay_ms};
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end else if (item.now_ms < beacon_ff) begin
            written = 1'b1;
         end else if (sweep_due) begin
            last_in = item.now_ms;
            written = 1'b1;
            if (sweep_sum >= $signed({2'b00, cfg.pan_max})) begin
               angle_in = cfg.pan_max;
               down_in  = 1'b1;
            end else if (sweep_sum <= $signed({2'b00, cfg.pan_min})) begin
               angle_in = cfg.pan_min;
               down_in  = 1'b0;
            end else begin
               angle_in = sweep_sum[11:0];
            end
         end
      end
   end

   assign result.pan_angle     = angle_in;
   assign result.angle_written = written;
   assign result.glance_phase  = phase_in;
   assign result.sweeping_down = down_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff  <= CENTER_INIT;
         down_ff   <= 1'b0;
         last_ff   <= 32'd0;
         beacon_ff <= 32'd0;
         phase_ff  <= PH_WAIT;
         next_ff   <= 32'd0;
         hold_ff   <= 32'd0;
         target_ff <= CENTER_INIT;
         moved_ff  <= 1'b0;
      end else if (fire) begin
         angle_ff  <= angle_in;
         down_ff   <= down_in;
         last_ff   <= last_in;
         beacon_ff <= beacon_in;
         phase_ff  <= phase_in;
         next_ff   <= next_in;
         hold_ff   <= hold_in;
         target_ff <= target_in;
         moved_ff  <= moved_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sensor_pan_scan_sequencer_core.sv
// top level of the pan scan sequencer: input register, tick engine, result register
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   sps_pkg::req_type  (one tick)
//   rsp      out        rsp_valid/rsp_stall   sps_pkg::rsp_type  (one result per tick)
//   csr      in         csr_valid/csr_ready   csr_index, csr_data (write only)
//
// one tick per clock sustained while rsp_stall is low; a tick is computed as it leaves
// the input register through the tick logic, and its result is held in the result register
// synchronous reset sets valid flags, settings and tick state at once, no clearing pass
// rsp_stall holds the result register; req_stall rises only when both stages are full
`default_nettype none
`include "assert_macros.svh"

module sensor_pan_scan_sequencer_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire sps_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output sps_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [sps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]                   csr_data
);
   import sps_pkg::*;

   cfg_type cfg;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;
   rsp_type tick_result;

   logic    accept;
   logic    advance;

   sps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sps_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (s1_ff),
      .cfg    (cfg),
      .result (tick_result)
   );

   // tick is processed as it moves into the result register
   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_data;
      end
      if (advance) begin
         out_ff <= tick_result;
      end
   end

   `ASSERT_NEVER(a_stall_empty, clock, reset, req_stall && !s1_valid_ff, "stall with empty input stage")
   `ASSERT_PROP(a_advance_fills, clock, reset, advance |=> rsp_valid, "advanced tick not presented")
   `ASSERT_PROP(a_seen_writes, clock, reset, advance && s1_ff.ir_seen |=> rsp_data.angle_written, "beacon tick without servo write")

endmodule

`default_nettype wire

>>> dv/tb_sensor_pan_scan_sequencer_core.sv
// testbench for the pan scan sequencer: directed ticks, then random ticks checked against a predictor
module tb_sensor_pan_scan_sequencer_core;
   import sps_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASES      = 6;
   localparam int unsigned PHASE_TICKS = 142;

   typedef struct packed {
      req_type tick;
      logic    typed;
      rsp_type want;
   } tick_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_data  = '0;

   // copy of the settings and the tick state, at their reset values
   cfg_type     pan_cfg = '{CENTER_INIT, 12'd480, 12'd2400, 10'd48, 16'd60,
                            10'd64, 16'd20, 16'd400};
   logic [11:0] pan_pos         = CENTER_INIT;
   logic        sweep_dn        = 1'b0;
   logic [31:0] last_step       = '0;
   logic [31:0] beacon_until    = '0;
   phase_type   ang_phase       = PH_WAIT;
   logic [31:0] glance_due      = '0;
   logic [31:0] glance_hold_end = '0;
   logic [11:0] glance_goal     = CENTER_INIT;
   logic        moving_prev     = 1'b0;

   rsp_type     pan_expect_q [$];
   int          mismatch_count = 0;
   int unsigned cycle_count    = 0;
   logic        calm           = 1'b0;
   logic [31:0] run_ms         = 32'd2000;
   logic        body_run       = 1'b0;

   tick_row_type tick_rows [22] = '{
      '{'{32'd0, 1'b1, 1'b0, 16'd0, 12'sd0}, 1'b1, '{12'd1440, 1'b1, PH_WAIT, 1'b0}},
      // inside the beacon hold window the angle is rewritten in place
      '{'{32'd5, 1'b0, 1'b0, 16'd0, 12'sd0}, 1'b1, '{12'd1440, 1'b1, PH_WAIT, 1'b0}},
      '{'{32'd1000, 1'b0, 1'b0, 16'd0, 12'sd0}, 1'b1, '{12'd1488, 1'b1, PH_WAIT, 1'b0}},
      '{'{32'd1010, 1'b0, 1'b1, 16'd0, 12'sd1440}, 1'b0, '0},
      '{'{32'd1030, 1'b0, 1'b1, 16'd0, 12'sd0}, 1'b0, '0},
      '{'{32'd1030, 1'b0, 1'b1, 16'd0, 12'sd0}, 1'b0, '0},
      '{'{32'd1050, 1'b1, 1'b1, 16'd0, 12'sd0}, 1'b0, '0},
      '{'{32'd1070, 1'b0, 1'b1, 16'd0, 12'sd0}, 1'b0, '0},
      '{'{32'd1100, 1'b0, 1'b0, 16'd0, 12'sd0}, 1'b0, '0},
      '{'{32'd1200, 1'b0, 1'b1, 16'd65535, -12'sd1440}, 1'b0, '0},
      '{'{32'd1300, 1'b0, 1'b1, 16'd0, -12'sd1440}, 1'b0, '0},
      '{'{32'd1400, 1'b0, 1'b0, 16'd0, 12'sd0}, 1'b0, '0},
      // arming time wraps to zero, so the glance starts at once and the arming time stays zero
      '{'{32'hFFFF_FFF6, 1'b0, 1'b1, 16'd10, 12'sd0}, 1'b0, '0},
      '{'{32'hFFFF_FFFF, 1'b0, 1'b1, 16'd1, -12'sd1}, 1'b0, '0},
      '{'{32'd0, 1'b0, 1'b1, 16'd0, 12'sd0}, 1'b0, '0},
      '{'{32'd40, 1'b0, 1'b1, 16'd0, 12'sd0}, 1'b0, '0},
      '{'{32'h8000_0000, 1'b0, 1'b0, 16'd0, 12'sd0}, 1'b0, '0},
      '{'{32'h8000_0000, 1'b0, 1'b0, 16'd0, 12'sd0}, 1'b0, '0},
      // hold window end wraps past zero
      '{'{32'hFFFF_FFFF, 1'b1, 1'b0, 16'd0, 12'sd0}, 1'b0, '0},
      '{'{32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 12'sd0}, 1'b0, '0},
      '{'{32'hAAAA_5555, 1'b0, 1'b1, 16'hAAAA, 12'sh555}, 1'b0, '0},
      '{'{32'h5555_AAAA, 1'b0, 1'b1, 16'h5555, -12'sd1365}, 1'b0, '0}
   };

   sensor_pan_scan_sequencer_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 8);
   end

   // one glance move of the angle toward goal
   task automatic glance_toward(input logic [11:0] goal, output bit hit);
      int delta;
      int mag;
      delta = int'(goal) - int'(pan_pos);
      mag   = (delta < 0) ? -delta : delta;
      hit   = (mag <= int'(pan_cfg.glance_step));
      if (hit) begin
         pan_pos = goal;
      end else if (delta > 0) begin
         pan_pos = pan_pos + 12'(pan_cfg.glance_step);
      end else begin
         pan_pos = pan_pos - 12'(pan_cfg.glance_step);
      end
   endtask

   task automatic pan_tick(input req_type t, output rsp_type r);
      logic [31:0] since;
      int          a;
      bit          hit;
      logic        wrote;
      wrote = 1'b0;
      since = t.now_ms - last_step;
      if (t.ir_seen) begin
         beacon_until = t.now_ms + IR_HOLD_MS;
         wrote = 1'b1;
      end else begin
         if (!t.in_motion && moving_prev) begin
            ang_phase  = PH_WAIT;
            glance_due = '0;
            pan_pos    = pan_cfg.pan_center;
            wrote      = 1'b1;
         end
         moving_prev = t.in_motion;
         if (t.in_motion) begin
            if (glance_due == '0) glance_due = t.now_ms + 32'(t.glance_delay_ms);
            if (ang_phase == PH_WAIT) begin
               pan_pos = pan_cfg.pan_center;
               wrote   = 1'b1;
               if (t.now_ms >= glance_due) begin
                  a = int'(pan_cfg.pan_center) + int'(t.glance_offset);
                  if (a < 0) a = 0;
                  if (a > int'(ANGLE_FULL)) a = int'(ANGLE_FULL);
                  glance_goal = 12'(a);
                  ang_phase   = PH_OUT;
                  last_step   = t.now_ms;
               end
            end else if (since >= 32'(pan_cfg.glance_period_ms)) begin
               last_step = t.now_ms;
               case (ang_phase)
                  PH_OUT: begin
                     glance_toward(glance_goal, hit);
                     if (hit) begin
                        ang_phase       = PH_HOLD;
                        glance_hold_end = t.now_ms + 32'(pan_cfg.glance_hold_ms);
                     end
                     wrote = 1'b1;
                  end
                  PH_HOLD: begin
                     if (t.now_ms >= glance_hold_end) ang_phase = PH_BACK;
                  end
                  default: begin
                     glance_toward(pan_cfg.pan_center, hit);
                     if (hit) begin
                        ang_phase  = PH_WAIT;
                        glance_due = t.now_ms + 32'(t.glance_delay_ms);
                     end
                     wrote = 1'b1;
                  end
               endcase
            end
         end else if (t.now_ms < beacon_until) begin
            wrote = 1'b1;
         end else if (since >= 32'(pan_cfg.sweep_period_ms)) begin
            last_step = t.now_ms;
            a = int'(pan_pos) + (sweep_dn ? -int'(pan_cfg.sweep_step)
                                          : int'(pan_cfg.sweep_step));
            // max limit is checked first, so crossed limits end on one of them
            if (a >= int'(pan_cfg.pan_max)) begin
               a = int'(pan_cfg.pan_max);
               sweep_dn = 1'b1;
            end else if (a <= int'(pan_cfg.pan_min)) begin
               a = int'(pan_cfg.pan_min);
               sweep_dn = 1'b0;
            end
            pan_pos = 12'(a);
            wrote   = 1'b1;
         end
      end
      r.pan_angle     = pan_pos;
      r.angle_written = wrote;
      r.glance_phase  = ang_phase;
      r.sweeping_down = sweep_dn;
   endtask

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pan_expect_q.size() == 0) begin
            flag_mismatch("unexpected result, pan_angle", -1, rsp_data.pan_angle);
         end else begin
            want = pan_expect_q.pop_front();
            if (rsp_data.pan_angle !== want.pan_angle)
               flag_mismatch("pan_angle", want.pan_angle, rsp_data.pan_angle);
            if (rsp_data.angle_written !== want.angle_written)
               flag_mismatch("angle_written", want.angle_written, rsp_data.angle_written);
            if (rsp_data.glance_phase !== want.glance_phase)
               flag_mismatch("glance_phase", want.glance_phase, rsp_data.glance_phase);
            if (rsp_data.sweeping_down !== want.sweeping_down)
               flag_mismatch("sweeping_down", want.sweeping_down, rsp_data.sweeping_down);
         end
      end
   end

   task automatic send_tick(input req_type t, input logic typed, input rsp_type want);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      pan_tick(t, predicted);
      pan_expect_q.push_back(typed ? want : predicted);
   endtask

   task automatic maybe_gap();
      if (!calm && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // stop sending and wait until every pending result has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (pan_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PAN_CENTER:       pan_cfg.pan_center       = val[11:0];
         CSR_PAN_MIN:          pan_cfg.pan_min          = val[11:0];
         CSR_PAN_MAX:          pan_cfg.pan_max          = val[11:0];
         CSR_SWEEP_STEP:       pan_cfg.sweep_step       = val[9:0];
         CSR_SWEEP_PERIOD_MS:  pan_cfg.sweep_period_ms  = val;
         CSR_GLANCE_STEP:      pan_cfg.glance_step      = val[9:0];
         CSR_GLANCE_PERIOD_MS: pan_cfg.glance_period_ms = val;
         default:              pan_cfg.glance_hold_ms   = val;
      endcase
   endtask

   task automatic write_settings(input cfg_type c);
      write_reg(CSR_PAN_CENTER, 16'(c.pan_center));
      write_reg(CSR_PAN_MIN, 16'(c.pan_min));
      write_reg(CSR_PAN_MAX, 16'(c.pan_max));
      write_reg(CSR_SWEEP_STEP, 16'(c.sweep_step));
      write_reg(CSR_SWEEP_PERIOD_MS, c.sweep_period_ms);
      write_reg(CSR_GLANCE_STEP, 16'(c.glance_step));
      write_reg(CSR_GLANCE_PERIOD_MS, c.glance_period_ms);
      write_reg(CSR_GLANCE_HOLD_MS, c.glance_hold_ms);
      csr_valid <= 1'b0;
   endtask

   function automatic cfg_type phase_settings(input int unsigned p);
      case (p)
         1: return '{12'd0, 12'd0, 12'd0, 10'd1, 16'd1, 10'd1, 16'd1, 16'd0};
         2: return '{12'd2880, 12'd2880, 12'd2880, 10'd720, 16'd65535,
                     10'd720, 16'd65535, 16'd65535};
         3: return '{12'd1440, 12'd0, 12'd2880, 10'd200, 16'd10, 10'd300, 16'd5, 16'd50};
         // limits out of order, a zero sweep step and zero periods, values past range
         4: return '{12'hFFF, 12'd2000, 12'd500, 10'd0, 16'd0, 10'h3FF, 16'd0, 16'd0};
         default: return '{12'($urandom_range(0, 2880)), 12'($urandom_range(0, 1440)),
                           12'($urandom_range(1440, 2880)), 10'($urandom_range(1, 720)),
                           16'($urandom_range(1, 200)), 10'($urandom_range(1, 720)),
                           16'($urandom_range(1, 100)), 16'($urandom_range(0, 1000))};
      endcase
   endfunction

   // mostly a steady clock with runs of moving and stopped, some noise ticks
   task automatic make_tick(input int unsigned span, output req_type t);
      int off;
      off = int'($urandom_range(0, 2880)) - 1440;
      if ($urandom_range(0, 99) < 10) begin
         t.now_ms          = $urandom();
         t.ir_seen         = 1'($urandom_range(0, 1));
         t.in_motion       = 1'($urandom_range(0, 1));
         t.glance_delay_ms = 16'($urandom_range(0, 65535));
      end else begin
         run_ms = run_ms + $urandom_range(0, span);
         if ($urandom_range(0, 99) < 2) body_run = !body_run;
         t.now_ms          = run_ms;
         t.ir_seen         = ($urandom_range(0, 99) < 4);
         t.in_motion       = body_run;
         t.glance_delay_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                         : 16'($urandom_range(0, 600));
      end
      t.glance_offset = 12'(off);
   endtask

   initial begin : stimulus
      req_type     t;
      int unsigned span;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (tick_rows[i]) begin
         send_tick(tick_rows[i].tick, tick_rows[i].typed, tick_rows[i].want);
         maybe_gap();
      end
      for (int unsigned p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            drain();
            write_settings(phase_settings(p));
         end
         calm = (p == 3);
         case (p)
            1:       begin span = 4;     run_ms = 32'hFFFF_FF80; end
            2:       begin span = 30000; run_ms = $urandom(); end
            3:       span = 25;
            4:       begin span = 30;    run_ms = $urandom(); end
            5:       span = 150;
            default: span = 60;
         endcase
         for (int unsigned n = 0; n < PHASE_TICKS; n++) begin
            if (p == 5 && n == PHASE_TICKS / 2) drain();
            make_tick(span, t);
            send_tick(t, 1'b0, '0);
            maybe_gap();
         end
      end
      drain();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
